// ===== src/button_click_classifier_core_defines.svh =====
// ----------------------------------------------------------------------------
// Button click classifier assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("button click classifier assertion failed");
`define BCC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("button click classifier assertion failed");
`else
`define BCC_ASSERT(lbl, prop)
`define BCC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button click classifier package
// Widths, register indexes, reset values and result codes.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CLICKS_W   = 2;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [CLICKS_W-1:0]  clicks_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_PRESS_MS = 1'b0,
    REG_DOUBLE_WIN_MS = 1'b1
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 2'd0,
    KIND_FORWARD  = 2'd1,
    KIND_BACKWARD = 2'd2,
    KIND_LONG     = 2'd3
  } click_kind_t;

  localparam cfg_t    LONG_PRESS_RST = cfg_t'(1200);
  localparam cfg_t    DOUBLE_WIN_RST = cfg_t'(300);
  localparam clicks_t DOUBLE_CLICKS  = clicks_t'(2);

endpackage

// ===== src/button_click_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Button click classifier core
// Classifies polled button samples into forward, double and long presses.
// ----------------------------------------------------------------------------
// Each poll transaction yields exactly one result transaction. A poll is
// classified in the cycle it is accepted and its result lands in the output
// register on that edge, so one poll per cycle is sustained; in_ready only
// drops while the output register holds a result that is not being taken.
// The result is valid in the cycle after the poll is accepted.
`include "button_click_classifier_core_defines.svh"

module button_click_classifier_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_button_pressed,
  input  logic [bcc_pkg::NOW_W-1:0]     in_now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bcc_pkg::KIND_W-1:0]    out_click_kind
);
  import bcc_pkg::*;

  cfg_t        long_press_r, long_press_nxt;
  cfg_t        double_win_r, double_win_nxt;
  logic        held_r, held_nxt;
  logic        long_rep_r, long_rep_nxt;
  time_t       press_start_r, press_start_nxt;
  clicks_t     clicks_r, clicks_nxt;
  time_t       last_click_r, last_click_nxt;
  logic        out_valid_r, out_valid_nxt;
  click_kind_t kind_r, kind_nxt;

  time_t       now_t;
  time_t       hold_el;
  time_t       click_el;
  clicks_t     clicks_inc;
  logic        accept;

  assign in_ready       = !out_valid_r || out_ready;
  assign accept         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_click_kind = KIND_W'(kind_r);

  assign now_t      = time_t'(in_now_ms);
  assign hold_el    = now_t - press_start_r;
  assign click_el   = now_t - last_click_r;
  assign clicks_inc = clicks_r + clicks_t'(1);

  always_comb begin
    long_press_nxt = long_press_r;
    double_win_nxt = double_win_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_LONG_PRESS_MS: long_press_nxt = cfg_wdata;
        REG_DOUBLE_WIN_MS: double_win_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_nxt        = held_r;
    long_rep_nxt    = long_rep_r;
    press_start_nxt = press_start_r;
    clicks_nxt      = clicks_r;
    last_click_nxt  = last_click_r;
    kind_nxt        = KIND_NONE;
    priority if (in_button_pressed && !held_r) begin
      press_start_nxt = now_t;
      held_nxt        = 1'b1;
      long_rep_nxt    = 1'b0;
    end else if (in_button_pressed) begin
      if (!long_rep_r && (hold_el >= time_t'(long_press_r))) begin
        long_rep_nxt = 1'b1;
        kind_nxt     = KIND_LONG;
      end
    end else if (!held_r) begin
      kind_nxt = KIND_NONE;
    end else if (long_rep_r) begin
      held_nxt     = 1'b0;
      long_rep_nxt = 1'b0;
    end else if (click_el < time_t'(double_win_r)) begin
      held_nxt = 1'b0;
      if (clicks_inc >= DOUBLE_CLICKS) begin
        clicks_nxt     = '0;
        last_click_nxt = '0;
        kind_nxt       = KIND_BACKWARD;
      end else begin
        clicks_nxt = clicks_inc;
      end
    end else begin
      held_nxt       = 1'b0;
      clicks_nxt     = clicks_t'(1);
      last_click_nxt = now_t;
      kind_nxt       = KIND_FORWARD;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r  <= LONG_PRESS_RST;
      double_win_r  <= DOUBLE_WIN_RST;
      held_r        <= 1'b0;
      long_rep_r    <= 1'b0;
      press_start_r <= '0;
      clicks_r      <= '0;
      last_click_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      long_press_r <= long_press_nxt;
      double_win_r <= double_win_nxt;
      out_valid_r  <= out_valid_nxt;
      if (accept) begin
        held_r        <= held_nxt;
        long_rep_r    <= long_rep_nxt;
        press_start_r <= press_start_nxt;
        clicks_r      <= clicks_nxt;
        last_click_r  <= last_click_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_nxt;
    end
  end

  `BCC_ASSERT(a_long_needs_held, long_rep_r |-> held_r)
  `BCC_ASSERT(a_clicks_below_double, clicks_r < DOUBLE_CLICKS)
  `BCC_ASSERT(a_long_result_marks_state, (out_valid_r && (kind_r == KIND_LONG)) |-> long_rep_r)
  `BCC_ASSERT(a_stall_holds_state, (!accept && !$past(!rst_n)) |=> $stable(clicks_r))

endmodule

// ===== tb/button_click_classifier_core_tb.sv =====
// ----------------------------------------------------------------------------
// Button click classifier core testbench
// Feeds polls of button level and time, and checks every click kind returned.
// A clocked driver takes polls from a queue and a clocked monitor checks each
// result transaction against a classifier model kept in step with the poll
// transactions. Both sides idle and stall at random, and the register
// settings change between phases, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_click_classifier_core_tb;
  import bcc_pkg::*;

  typedef struct packed {
    logic  pressed;
    time_t now;
  } poll_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LONG_PRESS_MS;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_button_pressed = 1'b0;
  logic [NOW_W-1:0]     in_now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_W-1:0]    out_click_kind;

  // classifier model state and its copy of the registers
  logic    btn_held = 1'b0;
  logic    long_done = 1'b0;
  time_t   press_t0 = '0;
  clicks_t click_cnt = '0;
  time_t   last_click_t = '0;
  cfg_t    long_ms = LONG_PRESS_RST;
  cfg_t    dbl_win_ms = DOUBLE_WIN_RST;

  poll_t       polls_pending[$];
  click_kind_t kinds_due[$];
  click_kind_t kind_want;
  poll_t       poll_next;
  int          polls_queued = 0;
  int          polls_taken = 0;
  int          errors = 0;
  int          idle_pct = 25;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          holdoff_left = 0;
  bit          holdoff_req = 1'b0;
  time_t       stamp = '0;

  button_click_classifier_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_button_pressed(in_button_pressed),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_click_kind   (out_click_kind)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic click_kind_t classify_poll(logic pressed, time_t now);
    if (pressed && !btn_held) begin
      press_t0  = now;
      btn_held  = 1'b1;
      long_done = 1'b0;
      return KIND_NONE;
    end
    if (pressed) begin
      if (!long_done && time_t'(now - press_t0) >= time_t'(long_ms)) begin
        long_done = 1'b1;
        return KIND_LONG;
      end
      return KIND_NONE;
    end
    if (!btn_held) return KIND_NONE;
    btn_held = 1'b0;
    if (long_done) begin
      long_done = 1'b0;
      return KIND_NONE;
    end
    if (time_t'(now - last_click_t) < time_t'(dbl_win_ms)) begin
      click_cnt = click_cnt + clicks_t'(1);
      if (click_cnt >= DOUBLE_CLICKS) begin
        click_cnt    = '0;
        last_click_t = '0;
        return KIND_BACKWARD;
      end
      return KIND_NONE;
    end
    click_cnt    = clicks_t'(1);
    last_click_t = now;
    return KIND_FORWARD;
  endfunction

  // driver: advance to the next poll once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        kinds_due.push_back(classify_poll(in_button_pressed, in_now_ms));
        polls_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (polls_pending.size() > 0) begin
          poll_next = polls_pending.pop_front();
          in_valid          <= 1'b1;
          in_button_pressed <= poll_next.pressed;
          in_now_ms         <= poll_next.now;
          if ($urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else if (holdoff_req) begin
      holdoff_req  = 1'b0;
      holdoff_left = 60;
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      recv_stall = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (kinds_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, got click_kind %0d",
                 $time, out_click_kind);
        errors++;
      end else begin
        kind_want = kinds_due.pop_front();
        if (out_click_kind !== kind_want) begin
          $display("%0t: click_kind mismatch, expected %0d, got %0d",
                   $time, kind_want, out_click_kind);
          errors++;
        end
      end
    end
  end

  task automatic add_poll(logic pressed, time_t now);
    polls_pending.push_back('{pressed: pressed, now: now});
    polls_queued++;
  endtask

  task automatic drain();
    while (polls_taken != polls_queued || kinds_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_regs(cfg_t lp, cfg_t dw);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_LONG_PRESS_MS;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_index <= REG_DOUBLE_WIN_MS;
    cfg_wdata <= dw;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    long_ms    = lp;
    dbl_win_ms = dw;
  endtask

  function automatic int unsigned near(int unsigned lim);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return (lim == 0) ? 0 : lim - 1;
      2: return lim;
      3: return lim + 1;
      default: return $urandom_range(0, 2 * lim + 2);
    endcase
  endfunction

  task automatic gen_polls(int n);
    int                count;
    int                k;
    longint unsigned   hold;
    count = 0;
    while (count < n) begin
      case ($urandom_range(0, 9))
        0: begin
          add_poll(1'($urandom_range(0, 1)), time_t'($urandom()));
          count++;
        end
        1: begin
          add_poll(1'b0, stamp);
          count++;
        end
        2: stamp = stamp + time_t'($urandom());
        default: begin
          stamp = stamp + time_t'(near(32'(dbl_win_ms)));
          add_poll(1'b1, stamp);
          hold = $urandom_range(0, 1) ? 64'(near(32'(long_ms))) :
                                        64'($urandom_range(0, 3));
          k = $urandom_range(0, 3);
          for (int i = 1; i <= k; i++) add_poll(1'b1, time_t'(stamp + hold * i / k));
          stamp = time_t'(stamp + hold + $urandom_range(0, 2));
          add_poll(1'b0, stamp);
          count += k + 2;
        end
      endcase
    end
  endtask

  initial begin
    cfg_t long_set[7];
    cfg_t win_set[7];
    long_set = '{cfg_t'(0), cfg_t'(1), cfg_t'(65535), cfg_t'($urandom_range(1, 3000)),
                 cfg_t'(40), cfg_t'($urandom_range(1, 65535)), cfg_t'(900)};
    win_set  = '{cfg_t'(0), cfg_t'(1), cfg_t'(65535), cfg_t'($urandom_range(1, 2000)),
                 cfg_t'(250), cfg_t'($urandom_range(1, 65535)), cfg_t'(300)};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: wrap, long press at the limit, click cycles, window edge
    add_poll(1'b0, 32'h0000_0000);
    add_poll(1'b1, 32'hFFFF_FFFF);
    add_poll(1'b1, 32'h0000_0100);
    add_poll(1'b1, 32'h0000_04AE);
    add_poll(1'b1, 32'h0000_04AF);
    add_poll(1'b0, 32'h0000_0500);
    add_poll(1'b1, 32'h0000_1000);
    add_poll(1'b0, 32'h0000_1010);
    add_poll(1'b1, 32'h0000_1050);
    add_poll(1'b0, 32'h0000_1060);
    add_poll(1'b1, 32'h0000_0005);
    add_poll(1'b0, 32'h0000_000A);
    add_poll(1'b1, 32'h0000_0014);
    add_poll(1'b0, 32'h0000_001E);
    add_poll(1'b1, 32'h0000_3000);
    add_poll(1'b0, 32'h0000_3000);
    add_poll(1'b1, 32'h0000_3100);
    add_poll(1'b0, 32'h0000_312C);
    stamp = 32'h0000_4000;
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      idle_pct = (ph == 4 || ph == 6) ? 0 : 25;
      set_regs(long_set[ph], win_set[ph]);
      if (ph == 0) begin
        // zero limits: long press on the second pressed poll, every click forward
        add_poll(1'b1, stamp);
        add_poll(1'b1, stamp);
        add_poll(1'b0, stamp + 1);
        add_poll(1'b1, stamp + 2);
        add_poll(1'b0, stamp + 3);
        stamp = stamp + 4;
      end
      if (ph == 3) holdoff_req = 1'b1;
      if (ph == 1) stamp = 32'hFFFF_F000;
      gen_polls(115);
      drain();
    end

    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bcc_pkg.sv
src/button_click_classifier_core.sv
tb/button_click_classifier_core_tb.sv
